// ----- src/mfbp_pkg.sv -----
// ----------------------------------------------------------------------------
// mfbp_pkg
// Shared types and constants for the msb-first field bit packer.
// ----------------------------------------------------------------------------
package mfbp_pkg;

  localparam int unsigned FIELD_W   = 32;             // widest field
  localparam int unsigned CARRY_W   = 7;              // leftover bits below a byte
  localparam int unsigned WORK_W    = FIELD_W + CARRY_W;
  localparam int unsigned LEN_W     = 6;              // 0..39 fits
  localparam int unsigned CHAR_BITS = 6;
  localparam logic [5:0]  MAX_LEN   = 6'd32;
  localparam logic [3:0]  FULL_BYTE = 4'd8;

  typedef enum logic [2:0] {
    KIND_INT   = 3'd0,
    KIND_BIT   = 3'd1,
    KIND_CHAR  = 3'd2,
    KIND_PAD   = 3'd3,
    KIND_FLUSH = 3'd4
  } kind_t;

  // one queued work unit: field bits left aligned, bit count, flush mark
  typedef struct packed {
    logic               is_flush;
    logic [FIELD_W-1:0] bits;
    logic [LEN_W-1:0]   len;
  } entry_t;

  // 6-bit character code: 32..95 keep their low six bits, the rest give 0
  function automatic logic [CHAR_BITS-1:0] six_bit_code(input logic [7:0] c);
    logic [CHAR_BITS-1:0] code;
    code = '0;
    if (c[7:5] == 3'b010 || c[7:5] == 3'b001) begin
      code = c[5:0];
    end
    return code;
  endfunction

endpackage

// ----- src/mfbp_if.sv -----
// ----------------------------------------------------------------------------
// mfbp interfaces
// Valid/ready channels for packer items and packed stream bytes.
// ----------------------------------------------------------------------------
interface mfbp_item_if;
  logic        valid;
  logic        ready;
  logic [2:0]  req_type;
  logic [31:0] field_value;
  logic [5:0]  field_length;
  logic [7:0]  char_code;
  logic        fill_bit;

  modport source (output valid, req_type, field_value, field_length, char_code,
                  fill_bit, input ready);
  modport sink (input valid, req_type, field_value, field_length, char_code,
                fill_bit, output ready);
endinterface

interface mfbp_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic [3:0] bits_valid;
  logic       end_of_run;
  logic       stream_end;

  modport source (output valid, out_byte, bits_valid, end_of_run, stream_end,
                  input ready);
  modport sink (input valid, out_byte, bits_valid, end_of_run, stream_end,
                output ready);
endinterface

// ----- src/mfbp_front.sv -----
// ----------------------------------------------------------------------------
// mfbp_front
// Accepts items and turns each into a left-aligned field or a flush mark.
// ----------------------------------------------------------------------------
module mfbp_front (
  mfbp_item_if.sink        items,
  input  logic             q_full,
  output logic             push,
  output mfbp_pkg::entry_t entry
);

  logic [5:0] len_sat;
  logic [5:0] shift;
  logic       keep;

  assign len_sat = (items.field_length > mfbp_pkg::MAX_LEN) ? mfbp_pkg::MAX_LEN
                                                            : items.field_length;
  assign shift   = mfbp_pkg::MAX_LEN - len_sat;

  always_comb begin
    entry.is_flush = 1'b0;
    entry.bits     = '0;
    entry.len      = '0;
    keep           = 1'b0;
    unique case (mfbp_pkg::kind_t'(items.req_type))
      mfbp_pkg::KIND_INT: begin
        entry.bits = items.field_value << shift;
        entry.len  = len_sat;
        keep       = (len_sat != '0);
      end
      mfbp_pkg::KIND_BIT: begin
        entry.bits = {items.fill_bit, {(mfbp_pkg::FIELD_W-1){1'b0}}};
        entry.len  = 6'd1;
        keep       = 1'b1;
      end
      mfbp_pkg::KIND_CHAR: begin
        entry.bits = {mfbp_pkg::six_bit_code(items.char_code),
                      {(mfbp_pkg::FIELD_W-mfbp_pkg::CHAR_BITS){1'b0}}};
        entry.len  = 6'(mfbp_pkg::CHAR_BITS);
        keep       = 1'b1;
      end
      mfbp_pkg::KIND_PAD: begin
        entry.bits = {mfbp_pkg::FIELD_W{items.fill_bit}} << shift;
        entry.len  = len_sat;
        keep       = (len_sat != '0);
      end
      mfbp_pkg::KIND_FLUSH: begin
        entry.is_flush = 1'b1;
        keep           = 1'b1;
      end
      default: begin
        keep = 1'b0;   // unused kinds are taken and dropped
      end
    endcase
  end

  assign items.ready = !q_full;
  assign push        = items.valid && !q_full && keep;

endmodule

// ----- src/mfbp_queue.sv -----
// ----------------------------------------------------------------------------
// mfbp_queue
// Two-entry queue between the item front end and the byte back end.
// ----------------------------------------------------------------------------
module mfbp_queue (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  mfbp_pkg::entry_t wr_entry,
  output logic             full,
  output logic             q_valid,
  output mfbp_pkg::entry_t rd_entry,
  input  logic             pop
);

  mfbp_pkg::entry_t slots [2];
  logic             wr_ptr;
  logic             rd_ptr;
  logic [1:0]       count;

  assign full     = (count == 2'd2);
  assign q_valid  = (count != 2'd0);
  assign rd_entry = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= wr_entry;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= !wr_ptr;
      end
      if (pop) begin
        rd_ptr <= !rd_ptr;
      end
      case ({push, pop})
        2'b10:   count <= count + 2'd1;
        2'b01:   count <= count - 2'd1;
        default: count <= count;
      endcase
    end
  end

`ifndef ASSERT_OFF
  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    full |-> !push) else $error("queue written while full");
  a_no_underflow: assert property (@(posedge clk) disable iff (rst)
    !q_valid |-> !pop) else $error("queue read while empty");
  a_count_range: assert property (@(posedge clk) disable iff (rst)
    count != 2'd3) else $error("queue count out of range");
`endif

endmodule

// ----- src/mfbp_back.sv -----
// ----------------------------------------------------------------------------
// mfbp_back
// Merges queued fields into the bit window and sends out one byte a cycle while the stream is ready.
// ----------------------------------------------------------------------------
module mfbp_back (
  input  logic             clk,
  input  logic             rst,
  input  logic             q_valid,
  input  mfbp_pkg::entry_t q_entry,
  output logic             pop,
  mfbp_byte_if.source      stream
);

  // window: pending bits left aligned at the top, zeros below
  logic [mfbp_pkg::WORK_W-1:0] win;
  logic [mfbp_pkg::WORK_W-1:0] win_next;
  logic [mfbp_pkg::LEN_W-1:0]  n;
  logic [mfbp_pkg::LEN_W-1:0]  n_next;

  logic [mfbp_pkg::WORK_W-1:0] win_b;
  logic [mfbp_pkg::LEN_W-1:0]  n_b;
  logic [mfbp_pkg::WORK_W-1:0] field_w;

  logic       out_valid;
  logic [7:0] out_byte;
  logic [3:0] bits_valid;
  logic       end_of_run;
  logic       stream_end;

  logic out_free;
  logic have_byte;
  logic emit_full;
  logic do_load;
  logic do_flush;
  logic emit_part;

  assign out_free  = !out_valid || stream.ready;
  assign have_byte = (n >= 6'd8);
  assign emit_full = have_byte && out_free;

  always_comb begin
    if (emit_full) begin
      win_b = win << 8;
      n_b   = n - 6'd8;
    end else begin
      win_b = win;
      n_b   = n;
    end
  end

  assign field_w   = {q_entry.bits, {mfbp_pkg::CARRY_W{1'b0}}} >> n_b;
  assign do_load   = q_valid && !q_entry.is_flush && (n_b < 6'd8);
  assign do_flush  = q_valid && q_entry.is_flush && !have_byte &&
                     ((n == '0) || out_free);
  assign emit_part = do_flush && (n != '0);
  assign pop       = do_load || do_flush;

  always_comb begin
    if (do_flush) begin
      win_next = '0;
      n_next   = '0;
    end else if (do_load) begin
      win_next = win_b | field_w;
      n_next   = n_b + q_entry.len;
    end else begin
      win_next = win_b;
      n_next   = n_b;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      win <= '0;
      n   <= '0;
    end else begin
      win <= win_next;
      n   <= n_next;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (emit_full || emit_part) begin
      out_valid <= 1'b1;
    end else if (stream.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit_full) begin
      out_byte   <= win[mfbp_pkg::WORK_W-1 -: 8];
      bits_valid <= mfbp_pkg::FULL_BYTE;
      end_of_run <= (n < 6'd16);
      stream_end <= 1'b0;
    end else if (emit_part) begin
      out_byte   <= win[mfbp_pkg::WORK_W-1 -: 8];
      bits_valid <= n[3:0];
      end_of_run <= 1'b1;
      stream_end <= 1'b1;
    end
  end

  assign stream.valid      = out_valid;
  assign stream.out_byte   = out_byte;
  assign stream.bits_valid = bits_valid;
  assign stream.end_of_run = end_of_run;
  assign stream.stream_end = stream_end;

`ifndef ASSERT_OFF
  a_count_max: assert property (@(posedge clk) disable iff (rst)
    n <= 6'(mfbp_pkg::WORK_W)) else $error("window count overrun");
  a_flush_clears: assert property (@(posedge clk) disable iff (rst)
    do_flush |=> n == '0) else $error("flush left bits pending");
  a_short_is_end: assert property (@(posedge clk) disable iff (rst)
    out_valid && !stream_end |-> bits_valid == mfbp_pkg::FULL_BYTE && n < 6'd8 ||
    out_valid && !stream_end && bits_valid == mfbp_pkg::FULL_BYTE)
    else $error("short byte without stream end");
  a_end_marks_run: assert property (@(posedge clk) disable iff (rst)
    out_valid && stream_end |-> end_of_run) else $error("stream end not last");
  a_load_no_byte: assert property (@(posedge clk) disable iff (rst)
    do_load |-> n_b < 6'd8) else $error("load with a whole byte waiting");
`endif

endmodule

// ----- src/msb_first_field_bit_packer.sv -----
// ----------------------------------------------------------------------------
// msb_first_field_bit_packer
// Packs integer, bit, 6-bit character and padding fields msb first into bytes.
// ----------------------------------------------------------------------------
// path: a field's first byte passes the queue, the bit window and the output register
// throughput: one item per cycle into a 2-entry queue while it is not full; the back
//   end sends one byte a cycle while the stream is ready
// the next load overlaps the last byte; a flush with bits left starts once that byte has left
// reset: synchronous, clears the queue, the pending bits and the output beat
module msb_first_field_bit_packer (
  input  logic        clk,
  input  logic        rst,
  mfbp_item_if.sink   items,
  mfbp_byte_if.source stream
);

  // front end to queue
  logic             push;
  mfbp_pkg::entry_t wr_entry;
  logic             q_full;

  // queue to back end
  logic             q_valid;
  mfbp_pkg::entry_t rd_entry;
  logic             pop;

  // classify: saturate the length, left align the field bits, drop no-ops
  mfbp_front u_front (
    .items  (items),
    .q_full (q_full),
    .push   (push),
    .entry  (wr_entry)
  );

  // short queue so an item beat is taken while bytes still drain
  mfbp_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .wr_entry (wr_entry),
    .full     (q_full),
    .q_valid  (q_valid),
    .rd_entry (rd_entry),
    .pop      (pop)
  );

  // bit window with carry; one stream beat per cycle through the output register while the stream is ready
  mfbp_back u_back (
    .clk     (clk),
    .rst     (rst),
    .q_valid (q_valid),
    .q_entry (rd_entry),
    .pop     (pop),
    .stream  (stream)
  );

endmodule
